// ===== sv/sds_pkg.sv =====
// Shared types and constants of the SCAN disk scheduler.
`default_nettype none

package sds_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int CYL_BITS_DEF     = 16;

    localparam int FIELD_W    = 16;
    localparam int SEEK_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_CYLINDER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LEFT     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] CYLINDER_COUNT_RST = 16'd200;
    localparam logic [CFG_DATA_W-1:0] START_POSITION_RST = 16'd0;

    typedef struct packed {
        logic [FIELD_W-1:0] request_cylinder;
        logic               batch_end;
    } sds_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] target_cylinder;
        logic [FIELD_W-1:0] move_distance;
        logic [SEEK_W-1:0]  total_seek;
        logic               final_step;
    } sds_out_t;

endpackage

`default_nettype wire

// ===== sv/scan_disk_scheduler.sv =====
// SCAN disk scheduler: request store, selection scan and result register.
// Requests load at one word per cycle into a store of MAX_REQUESTS entries with one
// read port; a word with batch_end closes the batch and the input stalls until the
// last result of the schedule has been registered. Each result costs one read pass
// over the n stored requests, and two such passes on the step where the sweep
// reverses. The one read port of the request store sets that cost. The result
// register lets the next selection pass run while a result still waits to be taken.
`default_nettype none

module scan_disk_scheduler import sds_pkg::*; #(
    parameter int MAX_REQUESTS = MAX_REQUESTS_DEF,
    parameter int CYL_BITS     = CYL_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sds_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sds_out_t                   m_data
);

    localparam int ADDR_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
    localparam int SUM_W  = ((SEEK_W > CYL_BITS) ? SEEK_W : CYL_BITS) + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CFG_DATA_W-1:0]   cylinder_count_reg;
    logic [CFG_DATA_W-1:0]   start_position_reg;
    logic                    sweep_left_reg;

    logic [CYL_BITS-1:0]     store_mem [MAX_REQUESTS];
    logic [CYL_BITS-1:0]     rd_data_reg;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [CNT_W-1:0]        emitted_reg;
    logic                    rd_vld_reg;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic [MAX_REQUESTS:0]   served_reg;
    logic                    reversed_reg;
    logic                    have_best_reg;
    logic [CYL_BITS-1:0]     best_val_reg;
    logic [CNT_W-1:0]        best_idx_reg;
    logic [CYL_BITS-1:0]     head_reg;
    logic [SEEK_W-1:0]       seek_reg;
    logic                    m_valid_reg;
    sds_out_t                m_data_reg;

    logic                    s_accept;
    logic                    store_we;
    logic [CYL_BITS-1:0]     store_wdata;
    logic [CYL_BITS-1:0]     start_c;
    logic [CYL_BITS-1:0]     es_val;
    logic                    want_right;
    logic                    rd_better;
    logic                    rd_take;
    logic                    es_better;
    logic                    es_take;
    logic                    pick_have;
    logic [CYL_BITS-1:0]     pick_val;
    logic [CNT_W-1:0]        pick_idx;
    logic [CYL_BITS-1:0]     dist_next;
    logic [SUM_W-1:0]        sum_wide;
    logic [SEEK_W-1:0]       seek_next;
    logic                    out_free;
    logic                    last_step;

    assign s_ready     = (state_reg == ST_LOAD);
    assign s_accept    = s_valid && s_ready;
    assign store_we    = s_accept && (count_reg < MAX_CNT);
    assign store_wdata = CYL_BITS'(s_data.request_cylinder);
    assign start_c     = CYL_BITS'(start_position_reg);
    assign es_val      = sweep_left_reg ? '0
                                        : CYL_BITS'(cylinder_count_reg) - CYL_BITS'(1);
    assign want_right  = ~(sweep_left_reg ^ reversed_reg);

    assign rd_better = want_right ? (rd_data_reg < best_val_reg)
                                  : (rd_data_reg > best_val_reg);
    assign rd_take   = rd_vld_reg && !served_reg[rd_idx_reg]
                       && ((rd_data_reg >= start_c) == want_right)
                       && (!have_best_reg || rd_better);

    assign es_better = want_right ? (es_val < best_val_reg) : (es_val > best_val_reg);
    assign es_take   = !served_reg[n_reg] && (!sweep_left_reg == want_right)
                       && (!have_best_reg || es_better);

    assign pick_have = have_best_reg || es_take;
    assign pick_val  = es_take ? es_val : best_val_reg;
    assign pick_idx  = es_take ? n_reg : best_idx_reg;

    assign dist_next = (best_val_reg >= head_reg) ? best_val_reg - head_reg
                                                  : head_reg - best_val_reg;
    assign sum_wide  = SUM_W'(seek_reg) + SUM_W'(dist_next);
    assign seek_next = (sum_wide > SUM_W'(SEEK_MAX)) ? SEEK_MAX : SEEK_W'(sum_wide);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (emitted_reg == n_reg);

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cylinder_count_reg <= CYLINDER_COUNT_RST;
            start_position_reg <= START_POSITION_RST;
            sweep_left_reg     <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CYLINDER_COUNT: cylinder_count_reg <= cfg_wdata;
                CFG_START_POSITION: start_position_reg <= cfg_wdata;
                CFG_SWEEP_LEFT:     sweep_left_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[count_reg[ADDR_W-1:0]] <= store_wdata;
        end
        rd_data_reg <= store_mem[issue_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            issue_reg     <= '0;
            emitted_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            served_reg    <= '0;
            reversed_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            head_reg      <= '0;
            seek_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        if (s_data.batch_end) begin
                            n_reg         <= store_we ? count_reg + CNT_W'(1) : count_reg;
                            count_reg     <= '0;
                            served_reg    <= '0;
                            reversed_reg  <= 1'b0;
                            have_best_reg <= 1'b0;
                            head_reg      <= start_c;
                            seek_reg      <= '0;
                            emitted_reg   <= '0;
                            issue_reg     <= '0;
                            rd_vld_reg    <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end else if (store_we) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    if (issue_reg != n_reg) begin
                        issue_reg  <= issue_reg + CNT_W'(1);
                        rd_idx_reg <= issue_reg;
                        rd_vld_reg <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if (rd_take) begin
                        have_best_reg <= 1'b1;
                        best_val_reg  <= rd_data_reg;
                        best_idx_reg  <= rd_idx_reg;
                    end
                    if (issue_reg == n_reg && !rd_vld_reg) begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK: begin
                    if (pick_have) begin
                        have_best_reg <= 1'b1;
                        best_val_reg  <= pick_val;
                        best_idx_reg  <= pick_idx;
                        state_reg     <= ST_EMIT;
                    end else if (!reversed_reg) begin
                        reversed_reg <= 1'b1;
                        issue_reg    <= '0;
                        state_reg    <= ST_SCAN;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.target_cylinder <= FIELD_W'(best_val_reg);
                        m_data_reg.move_distance   <= FIELD_W'(dist_next);
                        m_data_reg.total_seek      <= seek_next;
                        m_data_reg.final_step      <= last_step;
                        served_reg[best_idx_reg]   <= 1'b1;
                        head_reg                   <= best_val_reg;
                        seek_reg                   <= seek_next;
                        emitted_reg                <= emitted_reg + CNT_W'(1);
                        have_best_reg              <= 1'b0;
                        issue_reg                  <= '0;
                        state_reg                  <= last_step ? ST_LOAD : ST_SCAN;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/sds_checker.sv =====
// Port-level checks of the SCAN disk scheduler and their binding.
`default_nettype none

module sds_checker import sds_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire sds_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire sds_out_t m_data
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result word changed");

    a_batch_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.batch_end |=> !s_ready)
        else $error("input taken after batch end");

    a_drain_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.final_step |-> !s_ready)
        else $error("input open while schedule drains");

    a_seek_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (24'(m_data.move_distance) <= m_data.total_seek))
        else $error("move distance exceeds total seek");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (.*);

`default_nettype wire
